// ===== hdl/atc_pkg.sv =====
`timescale 1ns / 1ps

package atc_pkg;

    localparam int TAPS        = 8;
    localparam int SAMPLE_W    = 8;
    localparam int METRIC_W    = 17;
    localparam int SUM_SHIFT   = 8;
    // |sum| <= 255 * 348 < 2^17, so 18 signed bits never wrap
    localparam int SUM_W       = 18;
    localparam int CORR_W      = SUM_W - SUM_SHIFT;
    // |corr| <= 347, its square fits 17 unsigned bits
    localparam int ENERGY_W    = 17;
    localparam int DIFF_W      = ENERGY_W + 2;

    localparam logic [SAMPLE_W-1:0] MID_RESET = 8'd127;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic signed [SAMPLE_W:0]   centered_t;
    typedef centered_t [0:TAPS-1]       centered_vec_t;
    typedef logic signed [7:0]          coef_t;
    typedef coef_t [0:TAPS-1]           coef_vec_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [CORR_W-1:0]   corr_t;
    typedef logic [ENERGY_W-1:0]        energy_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [METRIC_W-1:0] metric_t;

    // index 0 is the oldest sample
    localparam coef_vec_t TAP_C1 = '{64, 45, 0, -45, -64, -45, 0, 45};
    localparam coef_vec_t TAP_S1 = '{0, 45, 64, 45, 0, -45, -64, -45};
    localparam coef_vec_t TAP_C2 = '{64, 8, -62, -24, 55, 39, -45, -51};
    localparam coef_vec_t TAP_S2 = '{0, 63, 17, -59, -32, 51, 45, -39};

    localparam metric_t METRIC_MAX = {1'b0, {(METRIC_W-1){1'b1}}};
    localparam metric_t METRIC_MIN = {1'b1, {(METRIC_W-1){1'b0}}};

    // Constant-coefficient dot product; the taps reduce to shift-add terms.
    function automatic corr_t correlate(input centered_vec_t d, input coef_vec_t taps);
        sum_t acc;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc = acc + (SUM_W'(d[i]) * SUM_W'(taps[i]));
        end
        // arithmetic shift right: keep the upper bits
        return acc[SUM_W-1:SUM_SHIFT];
    endfunction

    function automatic energy_t square(input corr_t x);
        logic signed [2*CORR_W-1:0] p;
        p = x * x;
        return p[ENERGY_W-1:0];
    endfunction

endpackage

// ===== hdl/afsk_tone_correlator_core.sv =====
`timescale 1ns / 1ps

// AFSK tone correlator: each accepted 8-bit ADC sample enters an eight-sample
// window (preset to code 127 at reset), the programmed midpoint is removed,
// and the window is correlated against 1200 Hz and 2200 Hz quadrature taps
// at 9600 samples/s. The result is the 2200 Hz energy minus the 1200 Hz
// energy, saturated to 17 bits signed, with high_tone set when the
// difference is positive. One result per sample, valid in the cycle after the
// sample is accepted; a sample is taken every cycle while the output is not
// stalled. Throughput is set by the single registered pass from the window to
// the output register. Write sample_midpoint only while no request is in flight.
module afsk_tone_correlator_core
    import atc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [16:0]  tone_metric,
    output logic                high_tone
);

    sample_t       window_reg [TAPS];
    sample_t       midpoint_reg;
    logic          out_valid_reg;
    metric_t       metric_reg;
    logic          high_reg;

    logic          accept;
    centered_vec_t centered;
    corr_t         c1, s1, c2, s2;
    energy_t       e_c1, e_s1, e_c2, e_s2;
    logic [ENERGY_W:0] e_high, e_low;
    diff_t         diff;
    metric_t       metric_next;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // window as it stands after this sample is shifted in
    always_comb
    begin
        for (int i = 0; i < TAPS - 1; i++)
        begin
            centered[i] = $signed({1'b0, window_reg[i+1]}) - $signed({1'b0, midpoint_reg});
        end
        centered[TAPS-1] = $signed({1'b0, sample}) - $signed({1'b0, midpoint_reg});
    end

    always_comb
    begin
        c1 = correlate(centered, TAP_C1);
        s1 = correlate(centered, TAP_S1);
        c2 = correlate(centered, TAP_C2);
        s2 = correlate(centered, TAP_S2);
        e_c1 = square(c1);
        e_s1 = square(s1);
        e_c2 = square(c2);
        e_s2 = square(s2);
        e_high = {1'b0, e_c2} + {1'b0, e_s2};
        e_low  = {1'b0, e_c1} + {1'b0, e_s1};
        diff   = $signed({1'b0, e_high}) - $signed({1'b0, e_low});
        if (diff > DIFF_W'(METRIC_MAX))
        begin
            metric_next = METRIC_MAX;
        end
        else if (diff < DIFF_W'(METRIC_MIN))
        begin
            metric_next = METRIC_MIN;
        end
        else
        begin
            metric_next = diff[METRIC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midpoint_reg <= MID_RESET;
        end
        else if (cfg_we)
        begin
            midpoint_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                window_reg[i] <= MID_RESET;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < TAPS - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[TAPS-1] <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            metric_reg <= metric_next;
            high_reg   <= (diff > 0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign tone_metric = metric_reg;
    assign high_tone   = high_reg;

endmodule

// ===== hdl/atc_checker.sv =====
`timescale 1ns / 1ps

module atc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [16:0] tone_metric,
    input logic               high_tone
);

    // a held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tone_metric) && $stable(high_tone))
        else $error("stalled result changed");

    // input side only backs up when the output register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // every accepted request yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // flag agrees with the metric sign
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (high_tone == (!tone_metric[16] && (tone_metric != 17'sd0))))
        else $error("high_tone disagrees with tone_metric");

endmodule

bind afsk_tone_correlator_core atc_checker u_atc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tone_metric (tone_metric),
    .high_tone   (high_tone)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import atc_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam int SETTLE_CYCLES = 4;

    // correlation taps, oldest sample first
    localparam int COS_LOW[8]  = '{64, 45, 0, -45, -64, -45, 0, 45};
    localparam int SIN_LOW[8]  = '{0, 45, 64, 45, 0, -45, -64, -45};
    localparam int COS_HIGH[8] = '{64, 8, -62, -24, 55, 39, -45, -51};
    localparam int SIN_HIGH[8] = '{0, 63, 17, -59, -32, 51, 45, -39};

    // strong windows for each tone plus a sampled 2200 Hz burst
    localparam logic [7:0] OPENING_SAMPLES[24] = '{
        8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0,
        8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255,
        8'd227, 8'd140, 8'd30, 8'd89, 8'd214, 8'd188, 8'd56, 8'd48
    };

    typedef struct packed {
        logic signed [16:0] metric;
        logic               high;
    } tone_result_t;

    class tone_scoreboard;
        logic [7:0]   window[8];
        logic [7:0]   midpoint;
        tone_result_t energy_q[$];
        int           failures;

        function new();
            foreach (window[i])
                window[i] = MID_RESET;
            midpoint = MID_RESET;
            failures = 0;
        endfunction

        function int pending();
            return energy_q.size();
        endfunction

        function void note_sample(logic [7:0] s);
            int           i;
            int           d;
            int           c_lo;
            int           s_lo;
            int           c_hi;
            int           s_hi;
            longint       diff;
            longint       clamped;
            tone_result_t r;
            for (i = 0; i < 7; i++)
                window[i] = window[i + 1];
            window[7] = s;
            c_lo = 0;
            s_lo = 0;
            c_hi = 0;
            s_hi = 0;
            for (i = 0; i < 8; i++)
            begin
                d = int'(window[i]) - int'(midpoint);
                c_lo += d * COS_LOW[i];
                s_lo += d * SIN_LOW[i];
                c_hi += d * COS_HIGH[i];
                s_hi += d * SIN_HIGH[i];
            end
            // signed shift floors toward minus infinity
            c_lo = c_lo >>> 8;
            s_lo = s_lo >>> 8;
            c_hi = c_hi >>> 8;
            s_hi = s_hi >>> 8;
            diff = longint'(c_hi) * c_hi + longint'(s_hi) * s_hi
                 - longint'(c_lo) * c_lo - longint'(s_lo) * s_lo;
            clamped = diff;
            if (clamped > 65535)
                clamped = 65535;
            if (clamped < -65536)
                clamped = -65536;
            r.metric = 17'(clamped);
            r.high = (diff > 0);
            energy_q.push_back(r);
        endfunction

        function void check_result(logic signed [16:0] metric, logic high);
            tone_result_t want;
            if (energy_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with no request pending: metric %0d high %0b",
                             $time, metric, high);
                return;
            end
            want = energy_q.pop_front();
            if (metric !== want.metric || high !== want.high)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: metric exp %0d got %0d, high exp %0b got %0b",
                             $time, want.metric, metric, want.high, high);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_wdata = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         sample = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [16:0] tone_metric;
    logic               high_tone;

    int send_idle_pct = 29;
    int stall_pct = 29;
    int hold_requests = 0;

    tone_scoreboard sb = new();

    afsk_tone_correlator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tone_metric (tone_metric),
        .high_tone   (high_tone)
    );

    initial
    begin
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("afsk_tone_correlator_core verification failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(tone_metric, high_tone);
        end
    end

    // each idle cycle is drawn on its own, so the sender idles about
    // send_idle_pct cycles of a hundred
    task automatic send_sample(input logic [7:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_midpoint(input logic [7:0] v);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.midpoint = v;
    endtask

    // mostly tone bursts around the current midpoint, the rest noise and rails
    task automatic run_random(input int count);
        int sent;
        int kind;
        int len;
        int amp;
        int ph;
        int v;
        int k;
        int rail;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(9);
            len = $urandom_range(8, 24);
            amp = $urandom_range(8, 255);
            ph = $urandom_range(7);
            case ($urandom_range(2))
                0: rail = 0;
                1: rail = 255;
                default: rail = sb.midpoint;
            endcase
            for (k = 0; k < len && sent < count; k++)
            begin
                if (kind <= 2)
                    v = int'(sb.midpoint) + amp * COS_LOW[(ph + k) % 8] / 64
                      + int'($urandom_range(6)) - 3;
                else if (kind <= 5)
                    v = int'(sb.midpoint) + amp * COS_HIGH[(ph + k) % 8] / 64
                      + int'($urandom_range(6)) - 3;
                else if (kind <= 7)
                    v = $urandom_range(255);
                else
                    v = rail;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                send_sample(v[7:0]);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [7:0] mids[8];
        int p;
        mids = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0, 8'd0, 8'd127};
        mids[5] = 8'($urandom_range(255));
        mids[6] = 8'($urandom_range(255));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window and midpoint first
        foreach (OPENING_SAMPLES[i])
            send_sample(OPENING_SAMPLES[i]);
        wait_drained();

        for (p = 0; p < 8; p++)
        begin
            write_midpoint(mids[p]);
            if (p == 3)
            begin
                // no idling either side; the hold-off backs the block up
                send_idle_pct = 0;
                stall_pct = 0;
                hold_requests++;
            end
            else
            begin
                send_idle_pct = 29;
                stall_pct = 29;
            end
            run_random(95);
            if (p == 5)
                wait_drained();
            run_random(95);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("afsk_tone_correlator_core verification clean");
        else
            $display("afsk_tone_correlator_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/atc_pkg.sv
hdl/afsk_tone_correlator_core.sv
hdl/atc_checker.sv
bench/tb.sv
